// ===== rtl/rrw_pkg.sv =====
// shared types and constants for the receive reorder window
package rrw_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_ARRIVE  = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_DUPLICATE     = 2'd1,
        ST_OUT_OF_WINDOW = 2'd2,
        ST_NOT_HELD      = 2'd3
    } status_t;

    localparam int SEQ_W   = 32;
    localparam int DESC_W  = 32;
    localparam int SPAN_W  = 6;
    localparam int COUNT_W = 6;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 6'd32;

    // request item
    typedef struct packed {
        kind_t              kind;
        logic [SEQ_W-1:0]   seq_number;
        logic [DESC_W-1:0]  descriptor;
    } req_t;

    // result item
    typedef struct packed {
        status_t             status;
        logic [SEQ_W-1:0]    out_seq;
        logic [DESC_W-1:0]   out_descriptor;
        logic [SEQ_W-1:0]    next_expected;
        logic [COUNT_W-1:0]  held_count;
    } rsp_t;

    // one slot of the reorder store
    typedef struct packed {
        logic               valid;
        logic [SEQ_W-1:0]   number;
        logic [DESC_W-1:0]  descriptor;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic slot_start;
        logic rd_en;
        logic commit;
        logic sweep_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t item_kind;
        logic  slot_done;
        logic  sweep_last;
        logic  occ_zero;
    } sts_t;

endpackage

// ===== rtl/rrw_ram.sv =====
// generic single-write, single-read ram with registered read data
module rrw_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rrw_slot_mod.sv =====
// slot index of a sequence number, derived from the expected number's slot and the offset
module rrw_slot_mod #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              seq,
    input  logic [31:0]              expected,
    input  logic [$clog2(DEPTH)-1:0] exp_slot,
    output logic [$clog2(DEPTH)-1:0] slot,
    output logic                     done
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam logic [SLOT_W:0] DEPTH_EXT = (SLOT_W + 1)'(DEPTH);

    logic [SLOT_W:0]   offset_low;
    logic [SLOT_W:0]   sum;
    logic [SLOT_W:0]   sum_wrap;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // a held number lies less than DEPTH past the expected one, so one
    // compare and subtract gives its slot; farther numbers are never held
    assign offset_low = seq[SLOT_W:0] - expected[SLOT_W:0];
    assign sum        = {1'b0, exp_slot} + offset_low;
    assign sum_wrap   = sum - DEPTH_EXT;

    // a number that wrapped past zero is below DEPTH and is its own slot
    always_comb
    begin
        if (seq < expected)
        begin
            slot_next = seq[SLOT_W-1:0];
        end
        else if (sum >= DEPTH_EXT)
        begin
            slot_next = sum_wrap[SLOT_W-1:0];
        end
        else
        begin
            slot_next = sum[SLOT_W-1:0];
        end
    end

    // slot register, loaded as the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (start)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;
    assign done = 1'b1;

endmodule

// ===== rtl/rrw_datapath.sv =====
// datapath: item capture, window check, slot store, expected number and result register
module rrw_datapath #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrw_pkg::req_t               req_item,
    input  logic                        cfg_write_en,
    input  logic [rrw_pkg::SPAN_W-1:0]  cfg_write_data,
    input  rrw_pkg::cmd_t               cmd,
    output rrw_pkg::sts_t               sts,
    output rrw_pkg::rsp_t               rsp_item
);

    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int OCC_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int ENTRY_W = $bits(rrw_pkg::entry_t);

    rrw_pkg::req_t                item_reg;
    rrw_pkg::rsp_t                rsp_reg, rsp_next;
    logic [31:0]                  expected_reg, expected_next;
    logic [SLOT_W-1:0]            exp_slot_reg, exp_slot_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic [rrw_pkg::SPAN_W-1:0]   span_reg;
    logic [SLOT_W-1:0]            sweep_reg, sweep_next;

    logic [SLOT_W-1:0]            seq_slot;
    logic                         seq_slot_done;
    logic [SLOT_W-1:0]            slot_sel;
    logic [ENTRY_W-1:0]           rd_bits;
    rrw_pkg::entry_t              rd_entry;
    rrw_pkg::entry_t              wr_entry;
    logic                         wr_hit;
    logic                         ram_we;
    logic [SLOT_W-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]           ram_wdata;

    logic                         held_seq;
    logic                         held_exp;
    logic [31:0]                  offset;
    logic [31:0]                  span_ext;
    logic [31:0]                  window;
    logic [31:0]                  exp_inc;

    // slot index of the incoming sequence number
    rrw_slot_mod #(
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.slot_start),
        .seq      (req_item.seq_number),
        .expected (expected_reg),
        .exp_slot (exp_slot_reg),
        .slot     (seq_slot),
        .done     (seq_slot_done)
    );

    // slot store
    rrw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (slot_sel),
        .rdata (rd_bits)
    );

    // deliver works on the expected slot, others on the item's slot
    assign slot_sel = (item_reg.kind == rrw_pkg::KIND_DELIVER) ? exp_slot_reg : seq_slot;
    assign rd_entry = rrw_pkg::entry_t'(rd_bits);

    // store write: sweep clears, commit updates one slot
    assign ram_we    = cmd.sweep_step || (cmd.commit && wr_hit);
    assign ram_waddr = cmd.sweep_step ? sweep_reg : slot_sel;
    assign ram_wdata = cmd.sweep_step ? '0 : ENTRY_W'(wr_entry);

    // window and hit checks
    assign held_seq = rd_entry.valid && (rd_entry.number == item_reg.seq_number);
    assign held_exp = rd_entry.valid && (rd_entry.number == expected_reg);
    assign offset   = item_reg.seq_number - expected_reg;
    assign span_ext = 32'(span_reg);
    assign window   = (span_ext > 32'(WINDOW_DEPTH)) ? 32'(WINDOW_DEPTH) : span_ext;
    assign exp_inc  = expected_reg + 32'd1;

    // item execution
    always_comb
    begin
        rsp_next      = '0;
        expected_next = expected_reg;
        exp_slot_next = exp_slot_reg;
        occ_next      = occ_reg;
        wr_hit        = 1'b0;
        wr_entry      = '0;
        rsp_next.status = rrw_pkg::ST_OK;
        unique case (item_reg.kind)
            rrw_pkg::KIND_ARRIVE:
            begin
                if (held_seq)
                begin
                    rsp_next.status = rrw_pkg::ST_DUPLICATE;
                end
                else if ((offset >= window) || rd_entry.valid)
                begin
                    rsp_next.status = rrw_pkg::ST_OUT_OF_WINDOW;
                end
                else
                begin
                    wr_hit              = 1'b1;
                    wr_entry.valid      = 1'b1;
                    wr_entry.number     = item_reg.seq_number;
                    wr_entry.descriptor = item_reg.descriptor;
                    occ_next            = occ_reg + OCC_W'(1);
                end
            end
            rrw_pkg::KIND_DELIVER:
            begin
                if (held_exp)
                begin
                    rsp_next.out_seq        = expected_reg;
                    rsp_next.out_descriptor = rd_entry.descriptor;
                    wr_hit                  = 1'b1;
                    wr_entry.valid          = 1'b0;
                    wr_entry.number         = rd_entry.number;
                    wr_entry.descriptor     = rd_entry.descriptor;
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                    expected_next = exp_inc;
                    // wrap of the number, or of the slot index past the last slot, restarts at slot zero
                    if ((exp_inc == '0) || (exp_slot_reg == SLOT_W'(WINDOW_DEPTH - 1)))
                    begin
                        exp_slot_next = '0;
                    end
                    else
                    begin
                        exp_slot_next = exp_slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    rsp_next.status = rrw_pkg::ST_NOT_HELD;
                end
            end
            rrw_pkg::KIND_QUERY:
            begin
                rsp_next.status = held_seq ? rrw_pkg::ST_OK : rrw_pkg::ST_NOT_HELD;
            end
            rrw_pkg::KIND_CLEAR:
            begin
                expected_next = '0;
                exp_slot_next = '0;
                occ_next      = '0;
            end
            default:
            begin
                rsp_next.status = rrw_pkg::ST_OK;
            end
        endcase
        rsp_next.next_expected = expected_next;
        rsp_next.held_count    = rrw_pkg::COUNT_W'(occ_next);
    end

    // sweep address
    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_step)
        begin
            sweep_next = (sweep_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : sweep_reg + SLOT_W'(1);
        end
    end

    // window state, configuration and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            exp_slot_reg <= '0;
            occ_reg      <= '0;
            span_reg     <= rrw_pkg::SPAN_RESET;
            sweep_reg    <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                expected_reg <= expected_next;
                exp_slot_reg <= exp_slot_next;
                occ_reg      <= occ_next;
            end
            if (cfg_write_en)
            begin
                span_reg <= cfg_write_data;
            end
            sweep_reg <= sweep_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_item;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_item       = rsp_reg;
    assign sts.item_kind  = item_reg.kind;
    assign sts.slot_done  = seq_slot_done;
    assign sts.sweep_last = (sweep_reg == SLOT_W'(WINDOW_DEPTH - 1));
    assign sts.occ_zero   = (occ_reg == '0);

endmodule

// ===== rtl/rrw_ctrl.sv =====
// controller: sequences each item and owns the result valid
module rrw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  rrw_pkg::kind_t req_kind,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  rrw_pkg::sts_t  sts,
    output rrw_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIPE,
        S_SLOT,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = req_valid && (state_reg == S_IDLE);
    assign out_free = !rsp_valid_reg || rsp_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (req_kind) inside
                        rrw_pkg::KIND_ARRIVE, rrw_pkg::KIND_QUERY:
                        begin
                            cmd.slot_start = 1'b1;
                            state_next     = S_SLOT;
                        end
                        rrw_pkg::KIND_DELIVER:
                        begin
                            state_next = S_SLOT;
                        end
                        rrw_pkg::KIND_CLEAR:
                        begin
                            state_next = sts.occ_zero ? S_EXEC : S_WIPE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WIPE:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_SLOT:
            begin
                if ((sts.item_kind == rrw_pkg::KIND_DELIVER) || sts.slot_done)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/receive_reorder_window_unit.sv =====
// top level of the selective-repeat receive reorder window
//
//   port group                    handshake          payload
//   req_valid / req_ready         valid-ready        req_item  (kind, seq_number, descriptor)
//   rsp_valid / rsp_ready         valid-ready        rsp_item  (status, out_seq, out_descriptor,
//                                                              next_expected, held_count)
//   cfg_write_en                  write strobe       cfg_write_data (window_span)
//
// one item at a time: arrive, query and deliver pass through the steps
// accept with slot index, store read and execute.
// clear goes from accept straight to execute with an empty store, else through the wipe sweep first.
// after reset every slot of the store is swept before req_ready rises.
// a stalled result holds in the output register; the next item is taken meanwhile
// and waits in its execute step until the result register frees.
module receive_reorder_window_unit #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  rrw_pkg::req_t               req_item,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output rrw_pkg::rsp_t               rsp_item,
    input  logic                        cfg_write_en,
    input  logic [rrw_pkg::SPAN_W-1:0]  cfg_write_data
);

    rrw_pkg::cmd_t cmd;
    rrw_pkg::sts_t sts;

    // sequencing
    rrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req_item.kind),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    rrw_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_item       (req_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .sts            (sts),
        .rsp_item       (rsp_item)
    );

endmodule

// ===== sim/receive_reorder_window_unit_tb.sv =====
// testbench for the receive reorder window: directed and randomized items checked against a behavioral predictor
`timescale 1ns / 100ps

module receive_reorder_window_unit_tb;

    localparam int DEPTH = 32;

    // what the driver does with one queued entry
    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_SPAN,
        ACT_DRAIN
    } stim_act_t;

    typedef struct {
        stim_act_t                   act;
        rrw_pkg::req_t               item;
        logic [rrw_pkg::SPAN_W-1:0]  span;
        int                          gap;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        req_valid = 1'b0;
    logic                        req_ready;
    rrw_pkg::req_t               req_item = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    rrw_pkg::rsp_t               rsp_item;
    logic                        cfg_write_en = 1'b0;
    logic [rrw_pkg::SPAN_W-1:0]  cfg_write_data = '0;

    // pending stimulus and expected results
    stim_t          stim_q[$];
    rrw_pkg::rsp_t  result_q[$];
    int             errors = 0;

    // predictor copy of the window state
    logic [rrw_pkg::SEQ_W-1:0]    exp_num;
    logic [rrw_pkg::COUNT_W-1:0]  held_total;
    logic [rrw_pkg::SPAN_W-1:0]   span_setting;
    logic                         slot_held [DEPTH];
    logic [rrw_pkg::SEQ_W-1:0]    slot_seq  [DEPTH];
    logic [rrw_pkg::DESC_W-1:0]   slot_desc [DEPTH];

    // driver working variables
    logic                        go_valid;
    rrw_pkg::req_t               go_item;
    logic                        go_cfg;
    logic [rrw_pkg::SPAN_W-1:0]  go_span;
    int                          gap_left = 0;
    rrw_pkg::rsp_t               want;
    logic                        sender_quiet = 1'b0;

    // monitor working variables
    int                 stall_left = 0;
    int                 results_seen = 0;
    logic               receiver_quiet = 1'b0;
    rrw_pkg::rsp_t      got;
    rrw_pkg::rsp_t      want_rsp;

    receive_reorder_window_unit #(
        .WINDOW_DEPTH (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_item       (req_item),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_item       (rsp_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // advance the window by one item and give the result it produces
    task automatic window_result(input rrw_pkg::req_t it, output rrw_pkg::rsp_t res);
        logic [rrw_pkg::SEQ_W-1:0]  offset;
        int unsigned                slot;
        int unsigned                eff;
        res = '0;
        res.status = rrw_pkg::ST_OK;
        eff = (span_setting > DEPTH) ? DEPTH : span_setting;
        case (it.kind)
            rrw_pkg::KIND_ARRIVE:
            begin
                slot = it.seq_number % DEPTH;
                offset = it.seq_number - exp_num;
                if (slot_held[slot] && slot_seq[slot] == it.seq_number)
                    res.status = rrw_pkg::ST_DUPLICATE;
                else if (offset >= eff || slot_held[slot])
                    res.status = rrw_pkg::ST_OUT_OF_WINDOW;
                else
                begin
                    slot_held[slot] = 1'b1;
                    slot_seq[slot] = it.seq_number;
                    slot_desc[slot] = it.descriptor;
                    held_total = held_total + 1'b1;
                end
            end
            rrw_pkg::KIND_DELIVER:
            begin
                slot = exp_num % DEPTH;
                if (slot_held[slot] && slot_seq[slot] == exp_num)
                begin
                    res.out_seq = exp_num;
                    res.out_descriptor = slot_desc[slot];
                    slot_held[slot] = 1'b0;
                    if (held_total != 0)
                        held_total = held_total - 1'b1;
                    exp_num = exp_num + 1'b1;
                end
                else
                    res.status = rrw_pkg::ST_NOT_HELD;
            end
            rrw_pkg::KIND_QUERY:
            begin
                slot = it.seq_number % DEPTH;
                if (!(slot_held[slot] && slot_seq[slot] == it.seq_number))
                    res.status = rrw_pkg::ST_NOT_HELD;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                    slot_held[i] = 1'b0;
                exp_num = '0;
                held_total = '0;
            end
        endcase
        res.next_expected = exp_num;
        res.held_count = held_total;
    endtask

    task automatic push_item(input rrw_pkg::kind_t k, input logic [rrw_pkg::SEQ_W-1:0] s,
                             input logic [rrw_pkg::DESC_W-1:0] d);
        stim_t e;
        e.act = ACT_ITEM;
        e.item.kind = k;
        e.item.seq_number = s;
        e.item.descriptor = d;
        e.span = '0;
        e.gap = sender_quiet ? 0 : $urandom_range(0, 3);
        stim_q.push_back(e);
    endtask

    task automatic push_span(input logic [rrw_pkg::SPAN_W-1:0] s);
        stim_t e;
        e.act = ACT_SPAN;
        e.item = '0;
        e.span = s;
        e.gap = 0;
        stim_q.push_back(e);
    endtask

    task automatic push_drain();
        stim_t e;
        e.act = ACT_DRAIN;
        e.item = '0;
        e.span = '0;
        e.gap = 0;
        stim_q.push_back(e);
    endtask

    // driver: request channel, config writes and prediction at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_num = '0;
            held_total = '0;
            span_setting = rrw_pkg::SPAN_RESET;
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_held[i] = 1'b0;
                slot_seq[i] = '0;
                slot_desc[i] = '0;
            end
            req_valid <= 1'b0;
            req_item <= '0;
            cfg_write_en <= 1'b0;
            cfg_write_data <= '0;
        end
        else
        begin
            go_valid = req_valid;
            go_item = req_item;
            go_cfg = 1'b0;
            go_span = cfg_write_data;
            if (cfg_write_en)
                span_setting = cfg_write_data;
            if (req_valid && req_ready)
            begin
                window_result(req_item, want);
                result_q.push_back(want);
                go_valid = 1'b0;
            end
            if (!go_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_q.size() > 0)
                begin
                    case (stim_q[0].act)
                        ACT_ITEM:
                        begin
                            go_valid = 1'b1;
                            go_item = stim_q[0].item;
                            gap_left = stim_q[0].gap;
                            stim_q.delete(0);
                        end
                        ACT_SPAN:
                        begin
                            // register writes only with the block idle
                            if (result_q.size() == 0)
                            begin
                                go_cfg = 1'b1;
                                go_span = stim_q[0].span;
                                stim_q.delete(0);
                            end
                        end
                        default:
                        begin
                            if (result_q.size() == 0)
                                stim_q.delete(0);
                        end
                    endcase
                end
            end
            req_valid <= go_valid;
            req_item <= go_item;
            cfg_write_en <= go_cfg;
            cfg_write_data <= go_span;
        end
    end

    // monitor: response channel with random stalls, compare against oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                got = rsp_item;
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: st=%0d seq=%h desc=%h exp=%h cnt=%0d",
                                 got.status, got.out_seq, got.out_descriptor,
                                 got.next_expected, got.held_count);
                end
                else
                begin
                    want_rsp = result_q.pop_front();
                    if (got.status !== want_rsp.status || got.out_seq !== want_rsp.out_seq ||
                        got.out_descriptor !== want_rsp.out_descriptor ||
                        got.next_expected !== want_rsp.next_expected ||
                        got.held_count !== want_rsp.held_count)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch got:  st=%0d seq=%h desc=%h exp=%h cnt=%0d",
                                     got.status, got.out_seq, got.out_descriptor,
                                     got.next_expected, got.held_count);
                            $display("mismatch want: st=%0d seq=%h desc=%h exp=%h cnt=%0d",
                                     want_rsp.status, want_rsp.out_seq,
                                     want_rsp.out_descriptor,
                                     want_rsp.next_expected, want_rsp.held_count);
                        end
                    end
                end
                results_seen++;
                if (results_seen % 40 == 0)
                    receiver_quiet = ($urandom_range(0, 3) == 0);
                stall_left = receiver_quiet ? 0 : $urandom_range(0, 3);
            end
            else if (stall_left > 0)
                stall_left--;
            rsp_ready <= (stall_left == 0);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int           ph;
        int           n;
        int           pick;
        int           off;
        int unsigned  eff;
        logic [rrw_pkg::SPAN_W-1:0] span_pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store, window edges, duplicates, wipe
        push_item(rrw_pkg::KIND_DELIVER, 32'h0, 32'h0);
        push_item(rrw_pkg::KIND_QUERY, 32'h0, 32'hffff_ffff);
        push_item(rrw_pkg::KIND_ARRIVE, 32'h0, 32'hffff_ffff);
        push_item(rrw_pkg::KIND_ARRIVE, 32'h0, 32'h0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd31, 32'h0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd32, 32'h1111_1111);
        push_item(rrw_pkg::KIND_ARRIVE, 32'hffff_ffff, 32'h1234_5678);
        push_item(rrw_pkg::KIND_QUERY, 32'd31, 32'h0);
        push_item(rrw_pkg::KIND_DELIVER, 32'hffff_ffff, 32'hffff_ffff);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd32, 32'ha5a5_a5a5);
        push_item(rrw_pkg::KIND_DELIVER, 32'h0, 32'h0);
        push_item(rrw_pkg::KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        push_item(rrw_pkg::KIND_CLEAR, 32'h0, 32'h0);
        // narrowest nonzero window
        push_span(6'd1);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd1, 32'h0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd0, 32'h5a5a_5a5a);
        // zero window, duplicate check still wins
        push_span(6'd0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd0, 32'h0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd1, 32'h0);
        push_item(rrw_pkg::KIND_QUERY, 32'hffff_ffff, 32'h0);
        push_item(rrw_pkg::KIND_DELIVER, 32'h0, 32'h0);
        // span above depth saturates
        push_span(6'd63);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd32, 32'h0000_0001);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd33, 32'h0);
        push_item(rrw_pkg::KIND_ARRIVE, 32'd1, 32'hffff_0000);
        push_item(rrw_pkg::KIND_DELIVER, 32'h0, 32'h0);
        push_item(rrw_pkg::KIND_CLEAR, 32'h0, 32'h0);
        push_drain();

        // random phases, arrivals around the expected number the largest share
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: span_pick = 6'd4;
                1: span_pick = 6'd63;
                2: span_pick = 6'd1;
                3: span_pick = 6'd32;
                4: span_pick = 6'd0;
                5: span_pick = rrw_pkg::SPAN_W'($urandom_range(1, 63));
                6: span_pick = 6'd2;
                default: span_pick = rrw_pkg::SPAN_W'($urandom_range(0, 63));
            endcase
            push_span(span_pick);
            eff = (span_pick > DEPTH) ? DEPTH : span_pick;
            for (n = 0; n < 80; n++)
            begin
                if (n % 25 == 0)
                    sender_quiet = ($urandom_range(0, 3) == 0);
                if (n == 40)
                    push_drain();
                while (stim_q.size() > 2)
                    @(posedge clk);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    off = $urandom_range(0, 99);
                    if (off < 30)
                        off = $urandom_range(0, 1);
                    else if (off < 85)
                        off = $urandom_range(0, eff + 1);
                    else
                        off = -$urandom_range(1, 3);
                    push_item(rrw_pkg::KIND_ARRIVE, exp_num + off, $urandom);
                end
                else if (pick < 75)
                    push_item(rrw_pkg::KIND_DELIVER, $urandom, $urandom);
                else if (pick < 85)
                    push_item(rrw_pkg::KIND_QUERY, exp_num + $urandom_range(0, eff + 1),
                              $urandom);
                else if (pick < 88)
                    push_item(rrw_pkg::KIND_CLEAR, $urandom, $urandom);
                else
                    push_item(rrw_pkg::kind_t'(2'($urandom_range(0, 3))), $urandom, $urandom);
            end
        end

        // let everything drain, then a short tail
        while (stim_q.size() != 0 || req_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("receive_reorder_window_unit_tb: done, clean");
        else
            $display("receive_reorder_window_unit_tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("receive_reorder_window_unit_tb: done, errors");
        $finish;
    end

endmodule
